### design/rfsd_pkg.sv
// Package with shared constants, types and helpers of the result frame stream decoder.
package rfsd_pkg;

    localparam int unsigned MAX_COLUMNS = 32768;
    localparam logic [30:0] CNT_MAX = 31'h7fffffff;

    // Parse phase codes.
    localparam logic [3:0] PH_KIND        = 4'd0;
    localparam logic [3:0] PH_SHAPE_COUNT = 4'd1;
    localparam logic [3:0] PH_STR_LEN     = 4'd2;
    localparam logic [3:0] PH_STR_BODY    = 4'd3;
    localparam logic [3:0] PH_ROW_TAG     = 4'd4;
    localparam logic [3:0] PH_ROW_WORD    = 4'd5;
    localparam logic [3:0] PH_ROW_LEN     = 4'd6;
    localparam logic [3:0] PH_ROW_BODY    = 4'd7;
    localparam logic [3:0] PH_ERR_CODE    = 4'd8;
    localparam logic [3:0] PH_ERR_LEN     = 4'd9;
    localparam logic [3:0] PH_ERR_BODY    = 4'd10;
    localparam logic [3:0] PH_END         = 4'd11;

    // Frame kind codes.
    localparam logic [7:0] KIND_SHAPE = 8'd1;
    localparam logic [7:0] KIND_ROW   = 8'd2;
    localparam logic [7:0] KIND_SET   = 8'd3;
    localparam logic [7:0] KIND_DONE  = 8'd4;
    localparam logic [7:0] KIND_ERROR = 8'd5;

    // Value tag codes.
    localparam logic [7:0] TAG_NULL  = 8'd0;
    localparam logic [7:0] TAG_INT   = 8'd1;
    localparam logic [7:0] TAG_FLOAT = 8'd2;
    localparam logic [7:0] TAG_TEXT  = 8'd3;
    localparam logic [7:0] TAG_BLOB  = 8'd4;

    localparam logic [63:0] NULL_FOLD = 64'd7;

    // One finished result.
    typedef struct packed {
        logic        status;
        logic        done_seen;
        logic [31:0] error_code;
        logic [30:0] set_count;
        logic [30:0] row_count;
        logic [30:0] value_count;
        logic [30:0] shape_count;
        logic [63:0] data_checksum;
        logic [63:0] meta_checksum;
    } result_t;

    // Saturating increment of a 31-bit count.
    function automatic logic [30:0] sat_inc(input logic [30:0] c);
        return (c == CNT_MAX) ? c : c + 31'd1;
    endfunction

    // fold = fold * 31 + v, as shift, subtract and add.
    function automatic logic [63:0] fold(input logic [63:0] acc, input logic [63:0] v);
        return (acc << 5) - acc + v;
    endfunction

endpackage

### design/result_frame_stream_decoder_unit.sv
// Top level of the result frame stream decoder: input register, parser, result register.
//
//  channel | direction | ports
//  s_      | in        | s_valid s_ready s_data_byte s_byte_present s_last_of_buffer
//  m_      | out       | m_valid m_ready m_status ... m_meta_checksum
//
// One byte per cycle while not stalled: a request is registered in the input
// register, decoded by the parser from there and, on the buffer's last request,
// its result is registered in the output register. Reset clears all decode state and valids.
// A stalled result holds the output register; the input register and parser
// stall only when a waiting last request meets a full output register.
module result_frame_stream_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_present,
    input  logic        s_last_of_buffer,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic        m_done_seen,
    output logic [31:0] m_error_code,
    output logic [30:0] m_set_count,
    output logic [30:0] m_row_count,
    output logic [30:0] m_value_count,
    output logic [30:0] m_shape_count,
    output logic signed [63:0] m_data_checksum,
    output logic signed [63:0] m_meta_checksum
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_present_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    rfsd_pkg::result_t out_reg;
    rfsd_pkg::result_t result;
    logic        out_free;
    logic        step;

    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || step;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_byte_reg    <= s_data_byte;
            in_present_reg <= s_byte_present;
            in_last_reg    <= s_last_of_buffer;
        end
    end

    rfsd_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .data_byte     (in_byte_reg),
        .byte_present  (in_present_reg),
        .last_of_buffer(in_last_reg),
        .result        (result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= step && in_last_reg;
        end
        if (out_free && step && in_last_reg) begin
            out_reg <= result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_reg.status;
    assign m_done_seen     = out_reg.done_seen;
    assign m_error_code    = out_reg.error_code;
    assign m_set_count     = out_reg.set_count;
    assign m_row_count     = out_reg.row_count;
    assign m_value_count   = out_reg.value_count;
    assign m_shape_count   = out_reg.shape_count;
    assign m_data_checksum = out_reg.data_checksum;
    assign m_meta_checksum = out_reg.meta_checksum;

    // A corrupt result carries no error code and no done flag.
    a_corrupt_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_error_code == 32'd0 && !m_done_seen))
        else $error("corrupt result carries data");
    // A good result was ended by done or a nonzero error code.
    a_good_term: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_status) |-> (m_done_seen || m_error_code != 32'd0))
        else $error("good result without terminator");
    // A stalled result is held.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data_checksum)))
        else $error("stalled result changed");

endmodule

### design/rfsd_parser.sv
// Frame parser: holds the decode state and folds one byte per request.
module rfsd_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic [7:0]            data_byte,
    input  logic                  byte_present,
    input  logic                  last_of_buffer,
    output rfsd_pkg::result_t     result
);

    logic [3:0]  phase_reg, phase_next;
    logic [2:0]  idx_reg, idx_next;
    logic [63:0] asm_reg, asm_next;
    logic [30:0] rem_reg, rem_next;
    logic [15:0] cols_reg, cols_next;
    logic        known_reg, known_next;
    logic [15:0] left_reg, left_next;
    logic        second_reg, second_next;
    logic [30:0] sets_reg, sets_next;
    logic [30:0] rows_reg, rows_next;
    logic [30:0] vals_reg, vals_next;
    logic [30:0] shapes_reg, shapes_next;
    logic [63:0] dfold_reg, dfold_next;
    logic [63:0] mfold_reg, mfold_next;
    logic        done_reg, done_next;
    logic [31:0] ecode_reg, ecode_next;
    logic        fault_reg, fault_next;

    logic [63:0] shifted;
    logic [31:0] word;
    logic        full4, full8;
    logic [15:0] left_dec;
    logic [30:0] rem_dec;
    logic        ok;

    assign shifted  = {asm_reg[55:0], data_byte};
    assign word     = shifted[31:0];
    assign full4    = (idx_reg == 3'd3);
    assign full8    = (idx_reg == 3'd7);
    assign left_dec = left_reg - 16'd1;
    assign rem_dec  = (rem_reg == 31'd0) ? 31'd0 : rem_reg - 31'd1;

    // Next-state decode of one byte.
    always_comb begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        asm_next    = asm_reg;
        rem_next    = rem_reg;
        cols_next   = cols_reg;
        known_next  = known_reg;
        left_next   = left_reg;
        second_next = second_reg;
        sets_next   = sets_reg;
        rows_next   = rows_reg;
        vals_next   = vals_reg;
        shapes_next = shapes_reg;
        dfold_next  = dfold_reg;
        mfold_next  = mfold_reg;
        done_next   = done_reg;
        ecode_next  = ecode_reg;
        fault_next  = fault_reg;
        if (byte_present && !fault_reg && phase_reg != rfsd_pkg::PH_END) begin
            unique case (phase_reg)
                rfsd_pkg::PH_KIND: begin
                    case (data_byte)
                        rfsd_pkg::KIND_SHAPE: begin
                            idx_next   = 3'd0;
                            phase_next = rfsd_pkg::PH_SHAPE_COUNT;
                        end
                        rfsd_pkg::KIND_ROW: begin
                            if (!known_reg) begin
                                fault_next = 1'b1;
                            end else begin
                                rows_next  = rfsd_pkg::sat_inc(rows_reg);
                                left_next  = cols_reg;
                                phase_next = (cols_reg != 16'd0) ? rfsd_pkg::PH_ROW_TAG
                                                                 : rfsd_pkg::PH_KIND;
                            end
                        end
                        rfsd_pkg::KIND_SET: begin
                            sets_next  = rfsd_pkg::sat_inc(sets_reg);
                            known_next = 1'b0;
                        end
                        rfsd_pkg::KIND_DONE: begin
                            done_next  = 1'b1;
                            phase_next = rfsd_pkg::PH_END;
                        end
                        rfsd_pkg::KIND_ERROR: begin
                            idx_next   = 3'd0;
                            phase_next = rfsd_pkg::PH_ERR_CODE;
                        end
                        default: fault_next = 1'b1;
                    endcase
                end
                rfsd_pkg::PH_SHAPE_COUNT: begin
                    asm_next = shifted;
                    idx_next = full4 ? 3'd0 : idx_reg + 3'd1;
                    if (full4) begin
                        if (word > 32'(rfsd_pkg::MAX_COLUMNS)) begin
                            fault_next = 1'b1;
                        end else begin
                            mfold_next  = rfsd_pkg::fold(mfold_reg, {32'd0, word});
                            cols_next   = word[15:0];
                            left_next   = word[15:0];
                            second_next = 1'b0;
                            if (word == 32'd0) begin
                                known_next  = 1'b1;
                                shapes_next = rfsd_pkg::sat_inc(shapes_reg);
                                phase_next  = rfsd_pkg::PH_KIND;
                            end else begin
                                known_next = 1'b0;
                                phase_next = rfsd_pkg::PH_STR_LEN;
                            end
                        end
                    end
                end
                rfsd_pkg::PH_STR_LEN, rfsd_pkg::PH_ROW_LEN, rfsd_pkg::PH_ERR_LEN: begin
                    asm_next = shifted;
                    idx_next = full4 ? 3'd0 : idx_reg + 3'd1;
                    if (full4) begin
                        if (word[31]) begin
                            fault_next = 1'b1;
                        end else begin
                            if (phase_reg == rfsd_pkg::PH_STR_LEN)
                                mfold_next = rfsd_pkg::fold(mfold_reg, {32'd0, word});
                            if (phase_reg == rfsd_pkg::PH_ROW_LEN)
                                dfold_next = rfsd_pkg::fold(dfold_reg, {32'd0, word});
                            rem_next = word[30:0];
                            if (word != 32'd0) begin
                                phase_next = phase_reg + 4'd1;
                            end else if (phase_reg == rfsd_pkg::PH_ERR_LEN) begin
                                phase_next = rfsd_pkg::PH_END;
                            end else if (phase_reg == rfsd_pkg::PH_ROW_LEN) begin
                                left_next  = left_dec;
                                phase_next = (left_dec != 16'd0) ? rfsd_pkg::PH_ROW_TAG
                                                                 : rfsd_pkg::PH_KIND;
                            end else if (!second_reg) begin
                                second_next = 1'b1;
                            end else begin
                                second_next = 1'b0;
                                left_next   = left_dec;
                                if (left_dec == 16'd0) begin
                                    known_next  = 1'b1;
                                    shapes_next = rfsd_pkg::sat_inc(shapes_reg);
                                    phase_next  = rfsd_pkg::PH_KIND;
                                end
                            end
                        end
                    end
                end
                rfsd_pkg::PH_STR_BODY: begin
                    mfold_next = rfsd_pkg::fold(mfold_reg, {56'd0, data_byte});
                    rem_next   = rem_dec;
                    if (rem_dec == 31'd0) begin
                        if (!second_reg) begin
                            second_next = 1'b1;
                            phase_next  = rfsd_pkg::PH_STR_LEN;
                        end else begin
                            second_next = 1'b0;
                            left_next   = left_dec;
                            if (left_dec == 16'd0) begin
                                known_next  = 1'b1;
                                shapes_next = rfsd_pkg::sat_inc(shapes_reg);
                                phase_next  = rfsd_pkg::PH_KIND;
                            end else begin
                                phase_next = rfsd_pkg::PH_STR_LEN;
                            end
                        end
                    end
                end
                rfsd_pkg::PH_ROW_TAG: begin
                    vals_next = rfsd_pkg::sat_inc(vals_reg);
                    case (data_byte)
                        rfsd_pkg::TAG_NULL: begin
                            dfold_next = rfsd_pkg::fold(dfold_reg, rfsd_pkg::NULL_FOLD);
                            left_next  = left_dec;
                            phase_next = (left_dec != 16'd0) ? rfsd_pkg::PH_ROW_TAG
                                                             : rfsd_pkg::PH_KIND;
                        end
                        rfsd_pkg::TAG_INT, rfsd_pkg::TAG_FLOAT: begin
                            idx_next   = 3'd0;
                            phase_next = rfsd_pkg::PH_ROW_WORD;
                        end
                        rfsd_pkg::TAG_TEXT, rfsd_pkg::TAG_BLOB: begin
                            idx_next   = 3'd0;
                            phase_next = rfsd_pkg::PH_ROW_LEN;
                        end
                        default: fault_next = 1'b1;
                    endcase
                end
                rfsd_pkg::PH_ROW_WORD: begin
                    asm_next = shifted;
                    idx_next = idx_reg + 3'd1;
                    if (full8) begin
                        dfold_next = rfsd_pkg::fold(dfold_reg, shifted);
                        left_next  = left_dec;
                        phase_next = (left_dec != 16'd0) ? rfsd_pkg::PH_ROW_TAG
                                                         : rfsd_pkg::PH_KIND;
                    end
                end
                rfsd_pkg::PH_ROW_BODY: begin
                    dfold_next = rfsd_pkg::fold(dfold_reg, {56'd0, data_byte});
                    rem_next   = rem_dec;
                    if (rem_dec == 31'd0) begin
                        left_next  = left_dec;
                        phase_next = (left_dec != 16'd0) ? rfsd_pkg::PH_ROW_TAG
                                                         : rfsd_pkg::PH_KIND;
                    end
                end
                rfsd_pkg::PH_ERR_CODE: begin
                    asm_next = shifted;
                    idx_next = full4 ? 3'd0 : idx_reg + 3'd1;
                    if (full4) begin
                        ecode_next = word;
                        phase_next = rfsd_pkg::PH_ERR_LEN;
                    end
                end
                rfsd_pkg::PH_ERR_BODY: begin
                    rem_next = rem_dec;
                    if (rem_dec == 31'd0) phase_next = rfsd_pkg::PH_END;
                end
                default: fault_next = 1'b1;
            endcase
        end
    end

    // Result of the buffer, built from the updated state.
    assign ok = !fault_next && phase_next == rfsd_pkg::PH_END &&
                (done_next || ecode_next != 32'd0);
    always_comb begin
        result        = '0;
        result.status = !ok;
        if (ok) begin
            result.done_seen     = done_next;
            result.error_code    = ecode_next;
            result.set_count     = sets_next;
            result.row_count     = rows_next;
            result.value_count   = vals_next;
            result.shape_count   = shapes_next;
            result.data_checksum = dfold_next;
            result.meta_checksum = mfold_next;
        end
    end

    // State registers; reset and the buffer's last request clear them.
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_of_buffer)) begin
            phase_reg  <= rfsd_pkg::PH_KIND;
            idx_reg    <= '0;
            asm_reg    <= '0;
            rem_reg    <= '0;
            cols_reg   <= '0;
            known_reg  <= 1'b0;
            left_reg   <= '0;
            second_reg <= 1'b0;
            sets_reg   <= '0;
            rows_reg   <= '0;
            vals_reg   <= '0;
            shapes_reg <= '0;
            dfold_reg  <= '0;
            mfold_reg  <= '0;
            done_reg   <= 1'b0;
            ecode_reg  <= '0;
            fault_reg  <= 1'b0;
        end else if (step) begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            asm_reg    <= asm_next;
            rem_reg    <= rem_next;
            cols_reg   <= cols_next;
            known_reg  <= known_next;
            left_reg   <= left_next;
            second_reg <= second_next;
            sets_reg   <= sets_next;
            rows_reg   <= rows_next;
            vals_reg   <= vals_next;
            shapes_reg <= shapes_next;
            dfold_reg  <= dfold_next;
            mfold_reg  <= mfold_next;
            done_reg   <= done_next;
            ecode_reg  <= ecode_next;
            fault_reg  <= fault_next;
        end
    end

endmodule

### tb/sv/result_frame_stream_decoder_unit_tb.sv
// Self-checking testbench for the result frame stream decoder top level.
`timescale 1ns / 100ps

module result_frame_stream_decoder_unit_tb;

    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [30:0] SAT31 = 31'h7fffffff;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_byte_present;
    logic        s_last_of_buffer;
    logic        m_valid;
    logic        m_ready;
    logic        m_status;
    logic        m_done_seen;
    logic [31:0] m_error_code;
    logic [30:0] m_set_count;
    logic [30:0] m_row_count;
    logic [30:0] m_value_count;
    logic [30:0] m_shape_count;
    logic signed [63:0] m_data_checksum;
    logic signed [63:0] m_meta_checksum;

    result_frame_stream_decoder_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data_byte(s_data_byte),
        .s_byte_present(s_byte_present), .s_last_of_buffer(s_last_of_buffer),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_done_seen(m_done_seen), .m_error_code(m_error_code),
        .m_set_count(m_set_count), .m_row_count(m_row_count),
        .m_value_count(m_value_count), .m_shape_count(m_shape_count),
        .m_data_checksum(m_data_checksum), .m_meta_checksum(m_meta_checksum)
    );

    // Decoder state mirrored by the predictor.
    logic [3:0]  dec_phase;
    logic [2:0]  dec_idx;
    logic [63:0] dec_asm;
    logic [30:0] dec_remain;
    logic [15:0] dec_cols;
    logic        dec_known;
    logic [15:0] dec_left;
    logic        dec_second;
    logic [30:0] dec_sets, dec_rows, dec_vals, dec_shapes;
    logic [63:0] dec_dfold, dec_mfold;
    logic        dec_done;
    logic [31:0] dec_err;
    logic        dec_fault;

    rfsd_pkg::result_t expected_results[$];
    int          mismatches;
    int          unexpected;
    bit          idle_enable;
    bit          timed_out;
    int unsigned cycles;

    // Byte-level buffer under construction.
    byte unsigned frame_bytes[$];

    always begin
        aclk = 1'b0; #4;
        aclk = 1'b1; #4;
    end

    function automatic logic [30:0] count_up(input logic [30:0] c);
        return (c == SAT31) ? c : c + 31'd1;
    endfunction

    function automatic logic [63:0] mix(input logic [63:0] acc, input logic [63:0] v);
        return acc * 64'd31 + v;
    endfunction

    task automatic clear_decoder();
        dec_phase = rfsd_pkg::PH_KIND; dec_idx = 0; dec_asm = 0; dec_remain = 0;
        dec_cols = 0; dec_known = 0; dec_left = 0; dec_second = 0;
        dec_sets = 0; dec_rows = 0; dec_vals = 0; dec_shapes = 0;
        dec_dfold = 0; dec_mfold = 0; dec_done = 0; dec_err = 0; dec_fault = 0;
    endtask

    // Shift a byte in; returns 1 when n bytes are complete.
    function automatic bit collect(input logic [7:0] b, input int n);
        dec_asm = {dec_asm[55:0], b};
        if (int'(dec_idx) + 1 >= n) begin
            dec_idx = 0;
            return 1;
        end
        dec_idx = dec_idx + 3'd1;
        return 0;
    endfunction

    function automatic void shape_complete();
        dec_known = 1;
        dec_shapes = count_up(dec_shapes);
        dec_phase = rfsd_pkg::PH_KIND;
    endfunction

    function automatic void name_type_done();
        if (!dec_second) begin
            dec_second = 1;
            dec_phase = rfsd_pkg::PH_STR_LEN;
        end else begin
            dec_second = 0;
            dec_left = dec_left - 16'd1;
            if (dec_left == 0) shape_complete();
            else dec_phase = rfsd_pkg::PH_STR_LEN;
        end
    endfunction

    function automatic void cell_done();
        dec_left = dec_left - 16'd1;
        dec_phase = (dec_left != 0) ? rfsd_pkg::PH_ROW_TAG : rfsd_pkg::PH_KIND;
    endfunction

    // Advance the decoder by one byte.
    function automatic void decode_byte(input logic [7:0] b);
        logic [31:0] w;
        w = 0;
        case (dec_phase)
            rfsd_pkg::PH_KIND: begin
                if (b == rfsd_pkg::KIND_SHAPE) begin
                    dec_idx = 0; dec_phase = rfsd_pkg::PH_SHAPE_COUNT;
                end else if (b == rfsd_pkg::KIND_ROW) begin
                    if (!dec_known) dec_fault = 1;
                    else begin
                        dec_rows = count_up(dec_rows);
                        dec_left = dec_cols;
                        dec_phase = (dec_left != 0) ? rfsd_pkg::PH_ROW_TAG
                                                    : rfsd_pkg::PH_KIND;
                    end
                end else if (b == rfsd_pkg::KIND_SET) begin
                    dec_sets = count_up(dec_sets); dec_known = 0;
                end else if (b == rfsd_pkg::KIND_DONE) begin
                    dec_done = 1; dec_phase = rfsd_pkg::PH_END;
                end else if (b == rfsd_pkg::KIND_ERROR) begin
                    dec_idx = 0; dec_phase = rfsd_pkg::PH_ERR_CODE;
                end else dec_fault = 1;
            end
            rfsd_pkg::PH_SHAPE_COUNT: if (collect(b, 4)) begin
                w = dec_asm[31:0];
                if (w > rfsd_pkg::MAX_COLUMNS) dec_fault = 1;
                else begin
                    dec_mfold = mix(dec_mfold, {32'd0, w});
                    dec_cols = w[15:0]; dec_left = w[15:0];
                    dec_known = 0; dec_second = 0;
                    if (w == 0) shape_complete();
                    else dec_phase = rfsd_pkg::PH_STR_LEN;
                end
            end
            rfsd_pkg::PH_STR_LEN: if (collect(b, 4)) begin
                w = dec_asm[31:0];
                if (w[31]) dec_fault = 1;
                else begin
                    dec_mfold = mix(dec_mfold, {32'd0, w});
                    if (w == 0) name_type_done();
                    else begin
                        dec_remain = w[30:0]; dec_phase = rfsd_pkg::PH_STR_BODY;
                    end
                end
            end
            rfsd_pkg::PH_STR_BODY: begin
                dec_mfold = mix(dec_mfold, {56'd0, b});
                if (dec_remain != 0) dec_remain = dec_remain - 31'd1;
                if (dec_remain == 0) name_type_done();
            end
            rfsd_pkg::PH_ROW_TAG: begin
                dec_vals = count_up(dec_vals);
                if (b == rfsd_pkg::TAG_NULL) begin
                    dec_dfold = mix(dec_dfold, rfsd_pkg::NULL_FOLD); cell_done();
                end else if (b == rfsd_pkg::TAG_INT || b == rfsd_pkg::TAG_FLOAT) begin
                    dec_idx = 0; dec_phase = rfsd_pkg::PH_ROW_WORD;
                end else if (b == rfsd_pkg::TAG_TEXT || b == rfsd_pkg::TAG_BLOB) begin
                    dec_idx = 0; dec_phase = rfsd_pkg::PH_ROW_LEN;
                end else dec_fault = 1;
            end
            rfsd_pkg::PH_ROW_WORD: if (collect(b, 8)) begin
                dec_dfold = mix(dec_dfold, dec_asm); cell_done();
            end
            rfsd_pkg::PH_ROW_LEN: if (collect(b, 4)) begin
                w = dec_asm[31:0];
                if (w[31]) dec_fault = 1;
                else begin
                    dec_dfold = mix(dec_dfold, {32'd0, w});
                    if (w == 0) cell_done();
                    else begin
                        dec_remain = w[30:0]; dec_phase = rfsd_pkg::PH_ROW_BODY;
                    end
                end
            end
            rfsd_pkg::PH_ROW_BODY: begin
                dec_dfold = mix(dec_dfold, {56'd0, b});
                if (dec_remain != 0) dec_remain = dec_remain - 31'd1;
                if (dec_remain == 0) cell_done();
            end
            rfsd_pkg::PH_ERR_CODE: if (collect(b, 4)) begin
                dec_err = dec_asm[31:0]; dec_phase = rfsd_pkg::PH_ERR_LEN;
            end
            rfsd_pkg::PH_ERR_LEN: if (collect(b, 4)) begin
                w = dec_asm[31:0];
                if (w[31]) dec_fault = 1;
                else if (w == 0) dec_phase = rfsd_pkg::PH_END;
                else begin
                    dec_remain = w[30:0]; dec_phase = rfsd_pkg::PH_ERR_BODY;
                end
            end
            rfsd_pkg::PH_ERR_BODY: begin
                if (dec_remain != 0) dec_remain = dec_remain - 31'd1;
                if (dec_remain == 0) dec_phase = rfsd_pkg::PH_END;
            end
            rfsd_pkg::PH_END: ;
            default: dec_fault = 1;
        endcase
    endfunction

    // Predict the effect of one accepted request.
    task automatic predict_request(input logic [7:0] b, input logic present,
                                   input logic last);
        rfsd_pkg::result_t r;
        bit ok;
        if (present && !dec_fault && dec_phase != rfsd_pkg::PH_END) decode_byte(b);
        if (last) begin
            ok = !dec_fault && dec_phase == rfsd_pkg::PH_END &&
                 (dec_done || dec_err != 0);
            r = '0;
            r.status = !ok;
            if (ok) begin
                r.done_seen = dec_done; r.error_code = dec_err;
                r.set_count = dec_sets; r.row_count = dec_rows;
                r.value_count = dec_vals; r.shape_count = dec_shapes;
                r.data_checksum = dec_dfold; r.meta_checksum = dec_mfold;
            end
            expected_results.push_back(r);
            clear_decoder();
        end
    endtask

    // Send one request, with a random leading gap when idling is enabled.
    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [7:0] b, input logic present,
                                input logic last);
        bit taken;
        while (idle_enable && $urandom_range(99) < 28) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_byte_present <= present;
        s_last_of_buffer <= last;
        taken = 1'b0;
        while (!taken) begin
            // Ready is settled between the falling edge and the next rising edge.
            #1;
            taken = s_ready;
            @(posedge aclk);
            if (!taken) @(negedge aclk);
        end
        predict_request(b, present, last);
        @(negedge aclk);
    endtask

    // Send the staged buffer; the last byte carries the end mark, and an empty buffer sends one byteless last request.
    task automatic send_buffer();
        int n;
        n = frame_bytes.size();
        if (n == 0) send_request(8'($urandom), 1'b0, 1'b1);
        for (int i = 0; i < n; i++)
            send_request(frame_bytes[i], 1'b1, i == n - 1);
        frame_bytes.delete();
    endtask

    task automatic put_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--) frame_bytes.push_back(w[8*i +: 8]);
    endtask

    task automatic put_string(input int len);
        put_word(len);
        for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom));
    endtask

    task automatic put_shape(input int ncols);
        frame_bytes.push_back(rfsd_pkg::KIND_SHAPE);
        put_word(ncols);
        for (int c = 0; c < ncols; c++) begin
            put_string($urandom_range(3));
            put_string($urandom_range(3));
        end
    endtask

    task automatic put_row(input int ncols);
        logic [7:0] tag;
        frame_bytes.push_back(rfsd_pkg::KIND_ROW);
        for (int c = 0; c < ncols; c++) begin
            tag = 8'($urandom_range(4));
            frame_bytes.push_back(tag);
            if (tag == rfsd_pkg::TAG_INT || tag == rfsd_pkg::TAG_FLOAT) begin
                for (int k = 0; k < 8; k++)
                    frame_bytes.push_back(($urandom_range(3) == 0) ? 8'hff : 8'($urandom));
            end else if (tag == rfsd_pkg::TAG_TEXT || tag == rfsd_pkg::TAG_BLOB) begin
                put_string($urandom_range(4));
            end
        end
    endtask

    task automatic put_error(input logic [31:0] code, input int len);
        frame_bytes.push_back(rfsd_pkg::KIND_ERROR);
        put_word(code);
        put_string(len);
    endtask

    // Result checker.
    always @(posedge aclk) begin
        rfsd_pkg::result_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_status, m_done_seen, m_error_code, m_set_count, m_row_count,
                    m_value_count, m_shape_count, m_data_checksum, m_meta_checksum};
            if (expected_results.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("unexpected result %h", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches + unexpected <= 10)
                        $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    // Receiver stalls.
    always @(negedge aclk)
        m_ready <= !idle_enable || ($urandom_range(99) >= 28);

    // Watchdog.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("result_frame_stream_decoder_unit verification failed");
            $finish;
        end
    end

    // Drop the input and wait until every expected result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (expected_results.size() != 0);
    endtask

    // Directed buffers: terminations, extremes and each fault.
    task automatic test_directed();
        int k;
        send_buffer();                                          // empty buffer
        frame_bytes.push_back(rfsd_pkg::KIND_DONE); send_buffer();
        put_shape(0); frame_bytes.push_back(rfsd_pkg::KIND_ROW);
        frame_bytes.push_back(rfsd_pkg::KIND_SET);
        frame_bytes.push_back(rfsd_pkg::KIND_DONE); frame_bytes.push_back(8'hff);
        send_buffer();                                          // trailing byte
        put_shape(2); put_row(2); put_row(2); frame_bytes.push_back(rfsd_pkg::KIND_SET);
        frame_bytes.push_back(rfsd_pkg::KIND_DONE); send_buffer();
        put_error(32'hffffffff, 2); frame_bytes.push_back(rfsd_pkg::KIND_SHAPE);
        send_buffer();
        put_error(0, 0); send_buffer();                         // code zero
        put_error(32'd1, 0); send_buffer();
        frame_bytes.push_back(rfsd_pkg::KIND_ROW); frame_bytes.push_back(rfsd_pkg::KIND_DONE);
        send_buffer();
        frame_bytes.push_back(8'd0); frame_bytes.push_back(rfsd_pkg::KIND_DONE);
        send_buffer();
        frame_bytes.push_back(rfsd_pkg::KIND_SHAPE); put_word(rfsd_pkg::MAX_COLUMNS + 1);
        send_buffer();
        frame_bytes.push_back(rfsd_pkg::KIND_SHAPE); put_word(1); put_word(32'h80000000);
        send_buffer();
        put_shape(1); frame_bytes.push_back(rfsd_pkg::KIND_ROW); frame_bytes.push_back(8'd5);
        send_buffer();                                          // bad tag
        put_shape(1); frame_bytes.push_back(rfsd_pkg::KIND_ROW);
        frame_bytes.push_back(rfsd_pkg::TAG_TEXT);
        put_word(32'hffffffff); send_buffer();
        frame_bytes.push_back(rfsd_pkg::KIND_ERROR); put_word(9); put_word(32'h80000000);
        send_buffer();
        put_shape(1); frame_bytes.push_back(rfsd_pkg::KIND_ROW); send_buffer(); // truncated
        // A bare non-last item at the start of a buffer.
        send_request(8'hff, 1'b0, 1'b0);
        frame_bytes.push_back(rfsd_pkg::KIND_DONE); send_buffer();
        // Largest legal column count, cut short after a few empty columns.
        frame_bytes.push_back(rfsd_pkg::KIND_SHAPE); put_word(rfsd_pkg::MAX_COLUMNS);
        for (k = 0; k < 3; k++) begin put_word(0); put_word(0); end
        frame_bytes.push_back(rfsd_pkg::KIND_DONE); send_buffer();  // truncated
    endtask

    // Random buffers: mostly well formed, some corrupted or cut short.
    task automatic test_random(input int byte_budget);
        int sent, ncols, nsets, nrows, pick, cut, k;
        sent = 0;
        while (sent < byte_budget) begin
            nsets = $urandom_range(2);
            for (int s = 0; s < nsets; s++) begin
                ncols = $urandom_range(3);
                put_shape(ncols);
                nrows = $urandom_range(3);
                for (int r = 0; r < nrows; r++) put_row(ncols);
                if ($urandom_range(1)) frame_bytes.push_back(rfsd_pkg::KIND_SET);
            end
            pick = $urandom_range(9);
            if (pick < 6) frame_bytes.push_back(rfsd_pkg::KIND_DONE);
            else if (pick < 8) put_error($urandom_range(1) ? $urandom : 0, $urandom_range(3));
            if ($urandom_range(3) == 0) frame_bytes.push_back(8'($urandom));
            // Occasionally corrupt or cut the buffer.
            pick = $urandom_range(9);
            if (pick == 0 && frame_bytes.size() > 0) begin
                k = $urandom_range(frame_bytes.size() - 1);
                frame_bytes[k] = 8'($urandom);
            end else if (pick == 1 && frame_bytes.size() > 1) begin
                cut = $urandom_range(frame_bytes.size() - 1);
                while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
            end
            sent += frame_bytes.size() + 1;
            send_buffer();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data_byte = 8'd0;
        s_byte_present = 1'b0;
        s_last_of_buffer = 1'b0;
        m_ready = 1'b0;
        idle_enable = 1'b1;
        mismatches = 0;
        unexpected = 0;
        timed_out = 0;
        cycles = 0;
        clear_decoder();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_random(520);
        // Hold the sender until all results are back.
        wait_drained();
        test_directed();
        idle_enable = 1'b0;
        test_random(360);
        idle_enable = 1'b1;
        test_random(560);

        wait_drained();
        repeat (20) @(negedge aclk);
        if (mismatches == 0 && unexpected == 0 && expected_results.size() == 0)
            $display("result_frame_stream_decoder_unit verification clean");
        else
            $display("result_frame_stream_decoder_unit verification failed");
        $finish;
    end

endmodule
